// ----- design/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, field widths, command codes and the structures that pass
// between the sequencer and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
  localparam int ADDR_W      = $clog2(CELL_COUNT);

  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = CHAR_W + 1;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] NORMAL_ATTR  = 8'h07;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic              scrolled;
    logic [CHAR_W-1:0] cell_char;
    logic [CHAR_W-1:0] cell_attr;
  } res_t;

endpackage

`default_nettype wire

// ----- design/tcw_if.sv -----
// ----------------------------------------------------------------------------
// Text console writer channels
// Valid/ready channels for incoming requests and outgoing results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_req_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::CMD_W-1:0]    command;
  logic [tcw_pkg::CHAR_W-1:0]   char_code;
  logic [tcw_pkg::ROW_W-1:0]    read_row;
  logic [tcw_pkg::COL_W-1:0]    read_col;

  modport source (output valid, command, char_code, read_row, read_col, input ready);
  modport sink (input valid, command, char_code, read_row, read_col, output ready);
endinterface

interface tcw_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [tcw_pkg::COL_W-1:0]    cursor_col;
  logic [tcw_pkg::ROW_W-1:0]    cursor_row;
  logic                         scrolled;
  logic [tcw_pkg::CHAR_W-1:0]   cell_char;
  logic [tcw_pkg::CHAR_W-1:0]   cell_attr;

  modport source (output valid, cursor_col, cursor_row, scrolled, cell_char, cell_attr,
                  input ready);
  modport sink (input valid, cursor_col, cursor_row, scrolled, cell_char, cell_attr,
                output ready);
endinterface

`default_nettype wire

// ----- design/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// Text console writer
// Character console for an 80x25 text screen. Requests arrive on req and
// each gives exactly one result on rsp; both are valid/ready channels.
// A put request stores one character at the cursor, wrapping on a newline or
// past the last column and scrolling when the cursor leaves the bottom row.
// A clear request blanks the screen and homes the cursor; a read request
// returns one cell. Requests are handled one at a time.
// A put that scrolls makes one store write per cell of the new bottom row and
// a clear one store write per cell, all through the single write port of the
// screen store. After reset the block sweeps the store to blank with req
// ready low. A result sits in an output register until taken, and the next
// request is accepted meanwhile; the engine holds its own result while that
// register is full and not being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer (
  input  wire logic clk,
  input  wire logic rst,
  tcw_req_if.sink   req,
  tcw_rsp_if.source rsp
);

  tcw_pkg::mem_req_t           mreq;
  logic [tcw_pkg::CELL_W-1:0]  rdata;
  logic                        res_valid;
  logic                        res_ready;
  tcw_pkg::res_t               res;
  logic                        out_valid;
  tcw_pkg::res_t               out_res;

  tcw_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .mreq      (mreq),
    .rdata     (rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELL_COUNT)
  ) u_screen (
    .clk   (clk),
    .we    (mreq.we),
    .waddr (mreq.waddr),
    .wdata (mreq.wdata),
    .re    (mreq.re),
    .raddr (mreq.raddr),
    .rdata (rdata)
  );

  assign res_ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.cursor_col = out_res.cursor_col;
  assign rsp.cursor_row = out_res.cursor_row;
  assign rsp.scrolled   = out_res.scrolled;
  assign rsp.cell_char  = out_res.cell_char;
  assign rsp.cell_attr  = out_res.cell_attr;

`ifndef SYNTHESIS
  a_row_on_screen: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.cursor_row <= tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS - 1))
    else $error("cursor row beyond the bottom of the screen");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.scrolled) |->
      (rsp.cursor_row == tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS - 1)) &&
      (rsp.cursor_col == tcw_pkg::COL_W'(1)))
    else $error("scroll left the cursor away from the start of the bottom row");

  a_attr_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.cell_attr == '0) || (rsp.cell_attr == tcw_pkg::NORMAL_ATTR))
    else $error("attribute neither blank nor normal");

  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(mreq.we && mreq.re))
    else $error("screen store written and read in the same cycle");

  a_no_lost_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |=> out_valid && $stable(out_res))
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

// ----- design/tcw_ram.sv -----
// ----------------------------------------------------------------------------
// Text console writer RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/tcw_seq.sv -----
// ----------------------------------------------------------------------------
// Text console writer sequencer
// Cursor and scroll base registers, and the controller that reads, writes and
// sweeps the screen store. Rows are held as a ring: a scroll advances the base
// row and blanks the single row that becomes the new bottom line.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_seq (
  input  wire logic                       clk,
  input  wire logic                       rst,
  tcw_req_if.sink                         req,
  output tcw_pkg::mem_req_t               mreq,
  input  wire logic [tcw_pkg::CELL_W-1:0] rdata,
  output logic                            res_valid,
  output tcw_pkg::res_t                   res,
  input  wire logic                       res_ready
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_RDATA,
    ST_SWEEP,
    ST_DONE
  } state_t;

  state_t                          state;
  tcw_pkg::cmd_t                   op;
  logic [tcw_pkg::COL_W-1:0]       col;
  logic [tcw_pkg::ROW_W-1:0]       row;
  logic [tcw_pkg::ROW_W-1:0]       base;
  logic [tcw_pkg::COL_W-1:0]       tgt_col;
  logic [tcw_pkg::ROW_W-1:0]       tgt_row;
  logic [tcw_pkg::CHAR_W-1:0]      char_r;
  logic                            scrolled;
  logic                            rd_hit;
  logic [tcw_pkg::ADDR_W-1:0]      sweep_cnt;
  logic [tcw_pkg::ADDR_W-1:0]      sweep_addr;

  tcw_pkg::cmd_t                   cmd;
  logic                            wrap;
  logic [tcw_pkg::COL_W-1:0]       put_col;
  logic [tcw_pkg::ROW_W-1:0]       put_row;
  logic                            put_scroll;
  logic [tcw_pkg::ROW_W-1:0]       base_inc;
  logic [tcw_pkg::ROW_W:0]         phys_sum;
  logic [tcw_pkg::ROW_W-1:0]       phys_row;
  logic [tcw_pkg::ADDR_W-1:0]      tgt_addr;
  logic                            rd_in_range;
  logic                            sweep_last;

  always_comb begin
    cmd        = tcw_pkg::cmd_t'(req.command);
    wrap       = (req.char_code == tcw_pkg::NEWLINE_CODE) ||
                 (col > tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLS - 1));
    put_col    = wrap ? '0 : col;
    put_row    = wrap ? tcw_pkg::ROW_W'(row + tcw_pkg::ROW_W'(1)) : row;
    put_scroll = put_row > tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS - 1);
    base_inc   = (base == tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS - 1)) ? '0 :
                 tcw_pkg::ROW_W'(base + tcw_pkg::ROW_W'(1));

    phys_sum   = {1'b0, tgt_row} + {1'b0, base};
    if (phys_sum >= (tcw_pkg::ROW_W + 1)'(tcw_pkg::SCREEN_ROWS)) begin
      phys_row = tcw_pkg::ROW_W'(phys_sum - (tcw_pkg::ROW_W + 1)'(tcw_pkg::SCREEN_ROWS));
    end else begin
      phys_row = tcw_pkg::ROW_W'(phys_sum);
    end
    tgt_addr    = tcw_pkg::ADDR_W'(phys_row) * tcw_pkg::ADDR_W'(tcw_pkg::SCREEN_COLS) +
                  tcw_pkg::ADDR_W'(tgt_col);
    rd_in_range = (tgt_row < tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS)) &&
                  (tgt_col < tcw_pkg::COL_W'(tcw_pkg::SCREEN_COLS));

    if (op != tcw_pkg::CMD_PUT) begin
      sweep_last = sweep_cnt == tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1);
    end else begin
      sweep_last = sweep_cnt == tcw_pkg::ADDR_W'(tcw_pkg::SCREEN_COLS - 1);
    end

    mreq = '0;
    case (state)
      ST_INIT, ST_SWEEP: begin
        mreq.we    = 1'b1;
        mreq.waddr = sweep_addr;
        if ((op == tcw_pkg::CMD_PUT) && (sweep_cnt == '0)) begin
          mreq.wdata = {1'b1, char_r};
        end
      end
      ST_EXEC: begin
        if (op == tcw_pkg::CMD_PUT) begin
          mreq.we    = 1'b1;
          mreq.waddr = tgt_addr;
          mreq.wdata = {1'b1, char_r};
        end else if ((op == tcw_pkg::CMD_READ) && rd_in_range) begin
          mreq.re    = 1'b1;
          mreq.raddr = tgt_addr;
        end
      end
      default: begin
      end
    endcase

    res_valid      = ((state == ST_EXEC) && (op == tcw_pkg::CMD_PUT)) ||
                     (state == ST_RDATA) || (state == ST_DONE);
    res.cursor_col = col;
    res.cursor_row = row;
    res.scrolled   = scrolled;
    res.cell_char  = rd_hit ? rdata[tcw_pkg::CHAR_W-1:0] : '0;
    res.cell_attr  = (rd_hit && rdata[tcw_pkg::CHAR_W]) ? tcw_pkg::NORMAL_ATTR : '0;
  end

  assign req.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      op         <= tcw_pkg::CMD_CLEAR;
      col        <= '0;
      row        <= '0;
      base       <= '0;
      scrolled   <= 1'b0;
      rd_hit     <= 1'b0;
      sweep_cnt  <= '0;
      sweep_addr <= '0;
    end else begin
      case (state)
        ST_INIT: begin
          sweep_cnt  <= sweep_cnt + tcw_pkg::ADDR_W'(1);
          sweep_addr <= sweep_addr + tcw_pkg::ADDR_W'(1);
          if (sweep_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req.valid) begin
            op       <= cmd;
            char_r   <= req.char_code;
            scrolled <= 1'b0;
            rd_hit   <= 1'b0;
            case (cmd)
              tcw_pkg::CMD_PUT: begin
                col       <= tcw_pkg::COL_W'(put_col + tcw_pkg::COL_W'(1));
                tgt_col   <= put_col;
                sweep_cnt <= '0;
                if (put_scroll) begin
                  row        <= tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS - 1);
                  tgt_row    <= tcw_pkg::ROW_W'(tcw_pkg::SCREEN_ROWS - 1);
                  scrolled   <= 1'b1;
                  base       <= base_inc;
                  sweep_addr <= tcw_pkg::ADDR_W'(base) *
                                tcw_pkg::ADDR_W'(tcw_pkg::SCREEN_COLS);
                  state      <= ST_SWEEP;
                end else begin
                  row     <= put_row;
                  tgt_row <= put_row;
                  state   <= ST_EXEC;
                end
              end
              tcw_pkg::CMD_CLEAR: begin
                col        <= '0;
                row        <= '0;
                base       <= '0;
                sweep_cnt  <= '0;
                sweep_addr <= '0;
                state      <= ST_SWEEP;
              end
              tcw_pkg::CMD_READ: begin
                tgt_row <= req.read_row;
                tgt_col <= req.read_col;
                state   <= ST_EXEC;
              end
              default: begin
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_EXEC: begin
          if (op == tcw_pkg::CMD_PUT) begin
            state <= res_ready ? ST_IDLE : ST_DONE;
          end else if (rd_in_range) begin
            rd_hit <= 1'b1;
            state  <= ST_RDATA;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_RDATA: begin
          state <= res_ready ? ST_IDLE : ST_DONE;
        end
        ST_SWEEP: begin
          sweep_cnt  <= sweep_cnt + tcw_pkg::ADDR_W'(1);
          sweep_addr <= sweep_addr + tcw_pkg::ADDR_W'(1);
          if (sweep_last) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives put, clear, read and unused requests into the console and checks
// every result against a shadow screen and cursor kept in the testbench, or
// for fixed directed rows against the table. A short directed table comes
// first, covering the field extremes, wrapping, scrolling and out-of-range
// reads. A long random stream follows. Both channels idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import tcw_pkg::*;

  localparam int REQ_COUNT    = 1500;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_SHOWN    = 10;

  typedef struct {
    cmd_t              cmd;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  rr;
    logic [COL_W-1:0]  rc;
    int                reps;
    bit                fixed;
    res_t              want;
  } stim_row_t;

  logic clk;
  logic rst;

  tcw_req_if req_bus ();
  tcw_rsp_if rsp_bus ();

  text_console_writer u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  logic [CELL_W-1:0] shadow_cells [CELL_COUNT];
  logic [COL_W-1:0]  shadow_col = '0;
  logic [ROW_W-1:0]  shadow_row = '0;
  res_t              expected_results [$];
  res_t              got_res;
  res_t              want_res;
  stim_row_t         directed_rows [$];

  int  errors        = 0;
  int  results_seen  = 0;
  int  requests_sent = 0;
  int  scrolls_seen  = 0;
  int  clears_sent   = 0;
  int  filled_reads  = 0;
  int  cycle_count   = 0;
  int  rsp_hold      = 0;
  bit  quiet         = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycle_count,
               expected_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic stim_row_t stim(cmd_t c, int ch, int rr, int rc, int reps, bit fixed,
                                     int col, int row, int scr, int cc, int ca);
    stim_row_t s;
    s.cmd   = c;
    s.ch    = CHAR_W'(ch);
    s.rr    = ROW_W'(rr);
    s.rc    = COL_W'(rc);
    s.reps  = reps;
    s.fixed = fixed;
    s.want  = '{COL_W'(col), ROW_W'(row), 1'(scr), CHAR_W'(cc), CHAR_W'(ca)};
    return s;
  endfunction

  // Applies one request to the shadow screen and returns the result it gives.
  function automatic res_t apply_request(cmd_t cmd, logic [CHAR_W-1:0] ch,
                                         logic [ROW_W-1:0] rr, logic [COL_W-1:0] rc);
    res_t              r;
    logic [CELL_W-1:0] entry;
    r = '0;
    case (cmd)
      CMD_PUT: begin
        if (ch == NEWLINE_CODE || shadow_col > COL_W'(SCREEN_COLS - 1)) begin
          shadow_col = '0;
          shadow_row = shadow_row + 1'b1;
        end
        if (shadow_row > ROW_W'(SCREEN_ROWS - 1)) begin
          for (int i = 0; i < CELL_COUNT - SCREEN_COLS; i++)
            shadow_cells[i] = shadow_cells[i + SCREEN_COLS];
          for (int i = CELL_COUNT - SCREEN_COLS; i < CELL_COUNT; i++)
            shadow_cells[i] = '0;
          shadow_row = ROW_W'(SCREEN_ROWS - 1);
          r.scrolled = 1'b1;
        end
        shadow_cells[int'(shadow_row) * SCREEN_COLS + int'(shadow_col)] = {1'b1, ch};
        shadow_col = shadow_col + 1'b1;
      end
      CMD_CLEAR: begin
        for (int i = 0; i < CELL_COUNT; i++)
          shadow_cells[i] = '0;
        shadow_col = '0;
        shadow_row = '0;
      end
      CMD_READ: begin
        if (int'(rr) < SCREEN_ROWS && int'(rc) < SCREEN_COLS) begin
          entry = shadow_cells[int'(rr) * SCREEN_COLS + int'(rc)];
          r.cell_char = entry[CHAR_W-1:0];
          r.cell_attr = entry[CHAR_W] ? NORMAL_ATTR : '0;
        end
      end
      default: begin
      end
    endcase
    r.cursor_col = shadow_col;
    r.cursor_row = shadow_row;
    return r;
  endfunction

  task automatic send_request(cmd_t cmd, logic [CHAR_W-1:0] ch, logic [ROW_W-1:0] rr,
                              logic [COL_W-1:0] rc, bit fixed, res_t want);
    int   gap;
    res_t predicted;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid     <= 1'b1;
    req_bus.command   <= cmd;
    req_bus.char_code <= ch;
    req_bus.read_row  <= rr;
    req_bus.read_col  <= rc;
    do @(posedge clk); while (!req_bus.ready);
    predicted = apply_request(cmd, ch, rr, rc);
    expected_results.push_back(fixed ? want : predicted);
    requests_sent++;
    if (cmd == CMD_CLEAR) clears_sent++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        results_seen++;
        got_res = '{rsp_bus.cursor_col, rsp_bus.cursor_row, rsp_bus.scrolled,
                    rsp_bus.cell_char, rsp_bus.cell_attr};
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= MAX_SHOWN)
            $display("Unexpected result at cycle %0d: col %0d row %0d scr %0b char %h attr %h",
                     cycle_count, got_res.cursor_col, got_res.cursor_row, got_res.scrolled,
                     got_res.cell_char, got_res.cell_attr);
        end else begin
          want_res = expected_results.pop_front();
          if (want_res.scrolled) scrolls_seen++;
          if (want_res.cell_attr == NORMAL_ATTR) filled_reads++;
          if (got_res.cursor_col !== want_res.cursor_col ||
              got_res.cursor_row !== want_res.cursor_row ||
              got_res.scrolled   !== want_res.scrolled   ||
              got_res.cell_char  !== want_res.cell_char  ||
              got_res.cell_attr  !== want_res.cell_attr) begin
            errors++;
            if (errors <= MAX_SHOWN) begin
              $display("Mismatch on result %0d: expected col %0d row %0d scr %0b char %h attr %h",
                       results_seen, want_res.cursor_col, want_res.cursor_row,
                       want_res.scrolled, want_res.cell_char, want_res.cell_attr);
              $display("  got col %0d row %0d scr %0b char %h attr %h",
                       got_res.cursor_col, got_res.cursor_row, got_res.scrolled,
                       got_res.cell_char, got_res.cell_attr);
            end
          end
        end
        rsp_hold = quiet ? 0 : $urandom_range(0, 4);
      end
      if (rsp_hold > 0) begin
        rsp_bus.ready <= 1'b0;
        rsp_hold--;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    stim_row_t         s;
    cmd_t              cmd;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  rr;
    logic [COL_W-1:0]  rc;
    int                pick;
    int                mode;

    req_bus.valid     = 1'b0;
    req_bus.command   = CMD_NOP;
    req_bus.char_code = '0;
    req_bus.read_row  = '0;
    req_bus.read_col  = '0;
    rsp_bus.ready     = 1'b0;
    rst               = 1'b1;
    for (int i = 0; i < CELL_COUNT; i++)
      shadow_cells[i] = '0;

    directed_rows.push_back(stim(CMD_READ,  0,    0,   0,  1, 1, 0, 0, 0, 0,    0));
    directed_rows.push_back(stim(CMD_READ,  0,    24,  79, 1, 1, 0, 0, 0, 0,    0));
    directed_rows.push_back(stim(CMD_PUT,   8'h41, 0,  0,  1, 1, 1, 0, 0, 0,    0));
    directed_rows.push_back(stim(CMD_READ,  0,    0,   0,  1, 1, 1, 0, 0, 8'h41, 7));
    directed_rows.push_back(stim(CMD_PUT,   8'hFF, 31, 127, 1, 1, 2, 0, 0, 0,   0));
    directed_rows.push_back(stim(CMD_PUT,   8'h00, 0,  0,  1, 1, 3, 0, 0, 0,    0));
    directed_rows.push_back(stim(CMD_READ,  0,    0,   2,  1, 1, 3, 0, 0, 0,    7));
    directed_rows.push_back(stim(CMD_READ,  0,    0,   3,  1, 1, 3, 0, 0, 0,    0));
    directed_rows.push_back(stim(CMD_PUT,   NEWLINE_CODE, 0, 0, 1, 1, 1, 1, 0, 0, 0));
    directed_rows.push_back(stim(CMD_READ,  0,    1,   0,  1, 1, 1, 1, 0, 8'h0A, 7));
    directed_rows.push_back(stim(CMD_READ,  8'hFF, 31, 127, 1, 1, 1, 1, 0, 0,   0));
    directed_rows.push_back(stim(CMD_READ,  0,    25,  0,  1, 1, 1, 1, 0, 0,    0));
    directed_rows.push_back(stim(CMD_READ,  0,    0,   80, 1, 1, 1, 1, 0, 0,    0));
    directed_rows.push_back(stim(CMD_NOP,   8'hFF, 31, 127, 1, 1, 1, 1, 0, 0,   0));
    directed_rows.push_back(stim(CMD_PUT,   8'h55, 0,  0,  79, 0, 0, 0, 0, 0,   0));
    directed_rows.push_back(stim(CMD_PUT,   8'h2A, 0,  0,  1, 1, 1, 2, 0, 0,    0));
    directed_rows.push_back(stim(CMD_PUT,   NEWLINE_CODE, 0, 0, 22, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(stim(CMD_PUT,   NEWLINE_CODE, 0, 0, 1, 1, 1, 24, 1, 0, 0));
    directed_rows.push_back(stim(CMD_READ,  0,    23,  0,  1, 0, 0, 0, 0, 0,    0));
    directed_rows.push_back(stim(CMD_PUT,   8'h7E, 0,  0,  79, 0, 0, 0, 0, 0,   0));
    directed_rows.push_back(stim(CMD_PUT,   8'h31, 0,  0,  1, 1, 1, 24, 1, 0,   0));
    directed_rows.push_back(stim(CMD_READ,  0,    23,  79, 1, 1, 1, 24, 0, 8'h7E, 7));
    directed_rows.push_back(stim(CMD_READ,  0,    24,  0,  1, 1, 1, 24, 0, 8'h31, 7));
    directed_rows.push_back(stim(CMD_CLEAR, 0,    0,   0,  1, 1, 0, 0, 0, 0,    0));
    directed_rows.push_back(stim(CMD_READ,  0,    23,  79, 1, 1, 0, 0, 0, 0,    0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      s = directed_rows[i];
      for (int k = 0; k < s.reps; k++)
        send_request(s.cmd, s.ch, s.rr, s.rc, s.fixed, s.want);
    end

    // Puts dominate, with frequent newlines so that the cursor reaches the
    // bottom row and scrolls often; reads favour the rows near the cursor.
    for (int n = 0; n < REQ_COUNT; n++) begin
      if (n % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 999);
      ch   = CHAR_W'($urandom_range(0, 255));
      rr   = ROW_W'($urandom_range(0, 31));
      rc   = COL_W'($urandom_range(0, 127));
      if (pick < 10) begin
        cmd = CMD_CLEAR;
      end else if (pick < 40) begin
        cmd = CMD_NOP;
      end else if (pick < 260) begin
        cmd  = CMD_READ;
        mode = $urandom_range(0, 9);
        if (mode < 6) begin
          rr = (shadow_row > 0 && $urandom_range(0, 1)) ? shadow_row - 1'b1 : shadow_row;
          rc = COL_W'($urandom_range(0, SCREEN_COLS - 1));
        end else if (mode < 8) begin
          rr = ROW_W'($urandom_range(0, SCREEN_ROWS - 1));
          rc = COL_W'($urandom_range(0, SCREEN_COLS - 1));
        end
      end else begin
        cmd = CMD_PUT;
        if ($urandom_range(0, 7) == 0) ch = NEWLINE_CODE;
      end
      send_request(cmd, ch, rr, rc, 1'b0, '0);
    end
    req_bus.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests and checked %0d results in %0d cycles.", requests_sent,
             results_seen, cycle_count);
    $display("The run saw %0d scrolls, %0d screen clears and %0d reads of written cells.",
             scrolls_seen, clears_sent, filled_reads);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches in total", errors);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/tcw_pkg.sv
design/tcw_if.sv
design/tcw_ram.sv
design/tcw_seq.sv
design/text_console_writer.sv
tb/tb.sv
